/* rtl/core/cds_pkg.sv */
// ----------------------------------------------------------------------------
// Calendar date step package
// Item types, stage records and calendar constants shared by the date stepper.
// ----------------------------------------------------------------------------
package cds_pkg;

	localparam int DAY_BITS   = 5;
	localparam int MONTH_BITS = 4;
	localparam int YEAR_BITS  = 16;

	localparam logic [MONTH_BITS-1:0] MONTH_JAN = 4'd1;
	localparam logic [MONTH_BITS-1:0] MONTH_FEB = 4'd2;
	localparam logic [MONTH_BITS-1:0] MONTH_DEC = 4'd12;

	localparam logic [DAY_BITS-1:0] DAY_FIRST    = 5'd1;
	localparam logic [DAY_BITS-1:0] DAYS_LEAP    = 5'd29;
	localparam logic [DAY_BITS-1:0] DAYS_DEC     = 5'd31;

	// Multiplicative inverse of 25 modulo 2**16. A year is a multiple of 25
	// exactly when year * INV25 (mod 2**16) does not exceed DIV25_MAX.
	localparam logic [YEAR_BITS-1:0] INV25     = 16'd23593;
	localparam logic [YEAR_BITS-1:0] DIV25_MAX = 16'd2621;

	typedef struct packed {
		logic [DAY_BITS-1:0]   day;
		logic [MONTH_BITS-1:0] month;
		logic [YEAR_BITS-1:0]  year;
	} cds_in_t;

	typedef struct packed {
		logic                  valid_res;
		logic [DAY_BITS-1:0]   month_length;
		logic [DAY_BITS-1:0]   next_day;
		logic [MONTH_BITS-1:0] next_month;
		logic [YEAR_BITS-1:0]  next_year;
		logic [DAY_BITS-1:0]   prev_day;
		logic [MONTH_BITS-1:0] prev_month;
		logic [YEAR_BITS-1:0]  prev_year;
	} cds_out_t;

	typedef struct packed {
		cds_in_t              date;
		logic [YEAR_BITS-1:0] prod;
	} cds_mul_t;

	typedef struct packed {
		cds_in_t             date;
		logic                leap;
		logic                ok;
		logic [DAY_BITS-1:0] len;
	} cds_len_t;

	function automatic logic [DAY_BITS-1:0] base_len(input logic [MONTH_BITS-1:0] m);
		logic [DAY_BITS-1:0] l;
		case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: l = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11:                     l = 5'd30;
			4'd2:                                        l = 5'd28;
			default:                                     l = 5'd0;
		endcase
		return l;
	endfunction

endpackage

/* rtl/core/calendar_date_step_top.sv */
// ----------------------------------------------------------------------------
// Calendar date step
// Checks a Gregorian date and returns its month length, next and previous day.
// ----------------------------------------------------------------------------
// An item on the date channel carries day, month and year. It is taken at a
// rising edge with date_valid high and date_stall low. For each item one
// result item leaves on the step channel, taken with step_valid high and
// step_stall low, in the order the dates arrived.
// The pipeline has four register stages: input register, inverse multiply
// for the divisibility-by-25 test, leap and length decision, and the output
// register holding next and previous date. One item is accepted per cycle
// when the receiver does not stall.
// When step_stall is high the result item holds steady, and each stage keeps
// its item until the stage after it has room, so no item is lost or repeated.
// date_stall rises only once every stage in front of the stall is full.
// Reset empties all stages; step_valid is low after reset and no stored
// dates need clearing.
// ----------------------------------------------------------------------------
module calendar_date_step_top (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              date_valid,
	output logic              date_stall,
	input  cds_pkg::cds_in_t  date,
	output logic              step_valid,
	input  logic              step_stall,
	output cds_pkg::cds_out_t step
);
	import cds_pkg::*;

	logic     front_ready;
	logic     mul_valid;
	cds_mul_t mul_data;
	logic     mul_ready;
	logic     len_valid;
	cds_len_t len_data;
	logic     len_ready;

	assign date_stall = !front_ready;

	cds_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (date_valid),
		.up_data  (date),
		.up_ready (front_ready),
		.dn_valid (mul_valid),
		.dn_data  (mul_data),
		.dn_ready (mul_ready)
	);

	cds_len u_len (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (mul_valid),
		.up_data  (mul_data),
		.up_ready (mul_ready),
		.dn_valid (len_valid),
		.dn_data  (len_data),
		.dn_ready (len_ready)
	);

	cds_step u_step (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (len_valid),
		.up_data  (len_data),
		.up_ready (len_ready),
		.dn_valid (step_valid),
		.dn_data  (step),
		.dn_ready (!step_stall)
	);

endmodule

/* rtl/core/cds_front.sv */
// ----------------------------------------------------------------------------
// Calendar date step front stages
// Registers the incoming item, then multiplies the year by the inverse of 25.
// ----------------------------------------------------------------------------
module cds_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            up_valid,
	input  cds_pkg::cds_in_t  up_data,
	output logic            up_ready,
	output logic            dn_valid,
	output cds_pkg::cds_mul_t dn_data,
	input  logic            dn_ready
);
	import cds_pkg::*;

	logic     vld_s1;
	logic     vld_s2;
	cds_in_t  date_s1;
	cds_mul_t mul_s2;
	logic     rdy_s1;
	logic     rdy_s2;
	logic [YEAR_BITS-1:0] prod;

	assign rdy_s2   = !vld_s2 || dn_ready;
	assign rdy_s1   = !vld_s1 || rdy_s2;
	assign up_ready = rdy_s1;
	assign prod     = YEAR_BITS'(date_s1.year * INV25);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (rdy_s1) begin
				vld_s1 <= up_valid;
			end
			if (rdy_s2) begin
				vld_s2 <= vld_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && up_valid) begin
			date_s1 <= up_data;
		end
		if (rdy_s2 && vld_s1) begin
			mul_s2.date <= date_s1;
			mul_s2.prod <= prod;
		end
	end

	assign dn_valid = vld_s2;
	assign dn_data  = mul_s2;

endmodule

/* rtl/core/cds_len.sv */
// ----------------------------------------------------------------------------
// Calendar date step length stage
// Decides the leap year, the month length and whether the date is valid.
// ----------------------------------------------------------------------------
module cds_len (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              up_valid,
	input  cds_pkg::cds_mul_t up_data,
	output logic              up_ready,
	output logic              dn_valid,
	output cds_pkg::cds_len_t dn_data,
	input  logic              dn_ready
);
	import cds_pkg::*;

	logic     vld_s3;
	cds_len_t len_s3;
	logic     rdy_s3;
	logic     div25;
	logic     leap;
	logic [DAY_BITS-1:0] len;
	logic     ok;

	assign rdy_s3   = !vld_s3 || dn_ready;
	assign up_ready = rdy_s3;

	always_comb begin
		div25 = (up_data.prod <= DIV25_MAX);
		leap  = div25 ? (up_data.date.year[3:0] == 4'd0) : (up_data.date.year[1:0] == 2'd0);
		len   = (up_data.date.month == MONTH_FEB && leap) ? DAYS_LEAP
		                                                  : base_len(up_data.date.month);
		ok    = (len != '0) && (up_data.date.day != '0) && (up_data.date.day <= len);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (rdy_s3) begin
			vld_s3 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s3 && up_valid) begin
			len_s3.date <= up_data.date;
			len_s3.leap <= leap;
			len_s3.ok   <= ok;
			len_s3.len  <= len;
		end
	end

	assign dn_valid = vld_s3;
	assign dn_data  = len_s3;

endmodule

/* rtl/core/cds_step.sv */
// ----------------------------------------------------------------------------
// Calendar date step output stage
// Forms the following and preceding dates and holds the result item.
// ----------------------------------------------------------------------------
module cds_step (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              up_valid,
	input  cds_pkg::cds_len_t up_data,
	output logic              up_ready,
	output logic              dn_valid,
	output cds_pkg::cds_out_t dn_data,
	input  logic              dn_ready
);
	import cds_pkg::*;

	logic     vld_s4;
	cds_out_t res_s4;
	logic     rdy_s4;
	cds_out_t res;
	logic [MONTH_BITS-1:0] pm;

	assign rdy_s4   = !vld_s4 || dn_ready;
	assign up_ready = rdy_s4;

	always_comb begin
		res = '0;
		pm  = up_data.date.month - MONTH_BITS'(1);
		if (up_data.ok) begin
			res.valid_res    = 1'b1;
			res.month_length = up_data.len;
			res.next_day     = up_data.date.day + DAY_BITS'(1);
			res.next_month   = up_data.date.month;
			res.next_year    = up_data.date.year;
			if (up_data.date.day == up_data.len) begin
				res.next_day = DAY_FIRST;
				if (up_data.date.month == MONTH_DEC) begin
					res.next_month = MONTH_JAN;
					res.next_year  = up_data.date.year + YEAR_BITS'(1);
				end else begin
					res.next_month = up_data.date.month + MONTH_BITS'(1);
				end
			end
			res.prev_day   = up_data.date.day - DAY_BITS'(1);
			res.prev_month = up_data.date.month;
			res.prev_year  = up_data.date.year;
			if (up_data.date.day == DAY_FIRST) begin
				if (up_data.date.month == MONTH_JAN) begin
					res.prev_month = MONTH_DEC;
					res.prev_year  = up_data.date.year - YEAR_BITS'(1);
					res.prev_day   = DAYS_DEC;
				end else begin
					res.prev_month = pm;
					res.prev_day   = (pm == MONTH_FEB && up_data.leap) ? DAYS_LEAP
					                                                  : base_len(pm);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (rdy_s4) begin
			vld_s4 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s4 && up_valid) begin
			res_s4 <= res;
		end
	end

	assign dn_valid = vld_s4;
	assign dn_data  = res_s4;

endmodule
